/* rtl/tlc_pkg.sv */
// shared constants and types for the two-way lru cache tag lookup
package tlc_pkg;

    localparam int SET_COUNT   = 64;
    localparam int OFFSET_BITS = 5;
    localparam int ADDR_BITS   = 32;

    localparam int SET_BITS   = $clog2(SET_COUNT);
    localparam int BLOCK_BITS = ADDR_BITS - OFFSET_BITS;
    localparam int TAG_BITS   = BLOCK_BITS - SET_BITS;
    localparam int CNT_BITS   = 32;

    typedef logic [ADDR_BITS-1:0]   t_addr;
    typedef logic [OFFSET_BITS-1:0] t_offset;
    typedef logic [BLOCK_BITS-1:0]  t_block;
    typedef logic [SET_BITS-1:0]    t_set;
    typedef logic [TAG_BITS-1:0]    t_tag;
    typedef logic [CNT_BITS-1:0]    t_cnt;

    // one row of the tag memory: both ways plus the replacement bit
    typedef struct packed {
        t_tag tag1;
        t_tag tag0;
        logic lru;
    } t_row;

endpackage

/* rtl/two_way_lru_cache_tag_lookup.sv */
// top level of the two-way lru cache tag lookup
//
//  channel  | signals                           | handshake
//  ---------+-----------------------------------+----------------------------------
//  request  | i_address                         | beat taken when start && !busy
//  result   | o_byte_offset .. o_miss_total     | one cycle beat marked by o_valid
//
// an address beat first gets the synchronous read of the tag memory row; then the
// compare writes the row back and registers the result for the result ports.
// busy is high only in the compare cycle, so no new beat is taken while a
// compare is under way; the single read/write port of the tag memory
// sets that pace. reset (synchronous, active low) clears valid bits, counters
// and control; tag memory contents stay undefined until written. the receiver
// cannot stall, so a result is dropped onto the ports for exactly one cycle.
module two_way_lru_cache_tag_lookup (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tlc_pkg::t_addr  i_address,
    output logic            o_valid,
    output tlc_pkg::t_offset o_byte_offset,
    output tlc_pkg::t_block o_block_number,
    output tlc_pkg::t_set   o_set_index,
    output logic            o_way_used,
    output tlc_pkg::t_tag   o_tag_value,
    output logic            o_is_miss,
    output logic            o_did_replace,
    output tlc_pkg::t_tag   o_evicted_tag,
    output tlc_pkg::t_cnt   o_hit_total,
    output tlc_pkg::t_cnt   o_miss_total
);
    import tlc_pkg::*;

    // tag memory, one row per set, read and written through one port
    t_row r_tag_mem [SET_COUNT];
    t_row r_rd_row;

    // valid bits live in flops so that reset clears them at once
    logic [SET_COUNT-1:0] r_valid0, r_valid1;
    logic [SET_COUNT-1:0] n_valid0, n_valid1;

    logic  r_busy;
    t_addr r_addr;
    t_cnt  r_hit, r_miss, n_hit, n_miss;

    logic  accept;
    t_set  in_set, cur_set;
    t_tag  cur_tag;
    logic  v0, v1;

    // compare cycle results
    t_row  n_row;
    logic  n_way, n_is_miss, n_replace;
    t_tag  n_evicted;

    // registered result beat
    logic  r_out_valid;
    t_addr r_out_addr;
    logic  r_out_way, r_out_miss, r_out_replace;
    t_tag  r_out_evicted;

    assign accept  = start && !r_busy;
    assign busy    = r_busy;
    assign in_set  = i_address[OFFSET_BITS +: SET_BITS];
    assign cur_set = r_addr[OFFSET_BITS +: SET_BITS];
    assign cur_tag = r_addr[ADDR_BITS-1 -: TAG_BITS];
    assign v0      = r_valid0[cur_set];
    assign v1      = r_valid1[cur_set];

    // memory read on accept, write back in the compare cycle; the two never
    // meet because no beat is taken while busy
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_row <= r_tag_mem[in_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_tag_mem[cur_set] <= n_row;
        end
    end

    // hit / fill / replace decision, way 0 filled before way 1
    always_comb begin
        n_row     = r_rd_row;
        n_way     = 1'b0;
        n_is_miss = 1'b0;
        n_replace = 1'b0;
        n_evicted = '0;
        n_valid0  = r_valid0;
        n_valid1  = r_valid1;
        if (!v0) begin
            n_is_miss         = 1'b1;
            n_row.tag0        = cur_tag;
            n_row.lru         = 1'b1;
            n_valid0[cur_set] = 1'b1;
        end else if (r_rd_row.tag0 == cur_tag) begin
            n_row.lru = 1'b1;
        end else if (!v1) begin
            n_is_miss         = 1'b1;
            n_way             = 1'b1;
            n_row.tag1        = cur_tag;
            n_row.lru         = 1'b0;
            n_valid1[cur_set] = 1'b1;
        end else if (r_rd_row.tag1 == cur_tag) begin
            n_way     = 1'b1;
            n_row.lru = 1'b0;
        end else begin
            n_is_miss = 1'b1;
            n_replace = 1'b1;
            if (r_rd_row.lru) begin
                n_way      = 1'b1;
                n_evicted  = r_rd_row.tag1;
                n_row.tag1 = cur_tag;
                n_row.lru  = 1'b0;
            end else begin
                n_evicted  = r_rd_row.tag0;
                n_row.tag0 = cur_tag;
                n_row.lru  = 1'b1;
            end
        end
        n_hit  = r_hit;
        n_miss = r_miss;
        if (n_is_miss) begin
            n_miss = CNT_BITS'(r_miss + 1'b1);
        end else begin
            n_hit = CNT_BITS'(r_hit + 1'b1);
        end
    end

    // control and state flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid0    <= '0;
            r_valid1    <= '0;
            r_hit       <= '0;
            r_miss      <= '0;
        end else begin
            r_busy      <= accept;
            r_out_valid <= r_busy;
            if (r_busy) begin
                r_valid0 <= n_valid0;
                r_valid1 <= n_valid1;
                r_hit    <= n_hit;
                r_miss   <= n_miss;
            end
        end
    end

    // payload flops
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_address;
        end
        if (r_busy) begin
            r_out_addr    <= r_addr;
            r_out_way     <= n_way;
            r_out_miss    <= n_is_miss;
            r_out_replace <= n_replace;
            r_out_evicted <= n_evicted;
        end
    end

    // counters already hold this beat's update when the result is shown
    assign o_valid        = r_out_valid;
    assign o_byte_offset  = r_out_addr[OFFSET_BITS-1:0];
    assign o_block_number = r_out_addr[ADDR_BITS-1:OFFSET_BITS];
    assign o_set_index    = r_out_addr[OFFSET_BITS +: SET_BITS];
    assign o_tag_value    = r_out_addr[ADDR_BITS-1 -: TAG_BITS];
    assign o_way_used     = r_out_way;
    assign o_is_miss      = r_out_miss;
    assign o_did_replace  = r_out_replace;
    assign o_evicted_tag  = r_out_evicted;
    assign o_hit_total    = r_hit;
    assign o_miss_total   = r_miss;

    // compare cycle never lasts longer than one cycle
    a_busy_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held for two cycles");

    // every compare cycle produces exactly one result beat
    a_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_out_valid)
        else $error("result beat missing after compare");

    // way 1 is only filled once way 0 is valid
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid1 & ~r_valid0) == '0)
        else $error("way 1 valid while way 0 invalid");

    // an eviction is always a miss
    a_replace_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_replace |-> r_out_miss)
        else $error("replacement reported on a hit");

    // exactly one counter moves per result beat
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_hit != $past(r_hit)) != (r_miss != $past(r_miss)))
        else $error("hit and miss counters out of step");

endmodule
